// ===== design/dst_pkg.sv =====
// Shared constants, codes and types for the de-duplicating set table.
package dst_pkg;

  localparam int CAPACITY  = 128;
  localparam int ITEM_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the input beat and register the compare results
    logic apply;    // carry out the operation and load the result register
  } dst_cmd_t;

endpackage

// ===== design/dst_ctrl.sv =====
// Controller of the set table: sequences lookup and update and owns the result valid.
module dst_ctrl
  import dst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output dst_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_APPLY;
        end
      end
      S_APPLY: begin
        // Hold the operation back until the result register can take it.
        if (out_free) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/dst_datapath.sv =====
// Datapath of the set table: row of element cells, parallel compare, shift and result register.
module dst_datapath
  import dst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dst_cmd_t             cmd,
  input  logic [1:0]           in_func,
  input  logic [ITEM_BITS-1:0] in_item,
  output logic                 res_found,
  output logic [7:0]           res_position,
  output logic [7:0]           res_count,
  output logic [1:0]           res_status
);

  logic [ITEM_BITS-1:0] cells_r [CAPACITY];
  logic [CAPACITY-1:0]  match_r, match_nxt;
  logic [ITEM_BITS-1:0] item_r;
  func_t                func_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 full;
  logic                 do_append;
  logic                 do_shift;
  status_t              status_nxt;

  // Every live cell compares against the incoming item in the same cycle.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (cells_r[i] == in_item) && (CNT_W'(i) < count_r);
    end
  end

  // Live entries are distinct, so at most one match bit is set.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit       = |match_r;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign do_append = cmd.apply && (func_r == OP_ADD) && !hit && !full;
  assign do_shift  = cmd.apply && (func_r == OP_REMOVE) && hit;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    case (func_r)
      OP_ADD: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      OP_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (do_append && (count_r == CNT_W'(g))) begin
          cells_r[g] <= item_r;
        end else if (do_shift && (IDX_W'(g) >= hit_idx)) begin
          cells_r[g] <= cells_r[g+1];
        end
      end
    end else begin : g_last
      // The top cell has no upper neighbour; after a removal it lies beyond the count.
      always_ff @(posedge clk) begin
        if (do_append && (count_r == CNT_W'(g))) begin
          cells_r[g] <= item_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_r <= match_nxt;
      item_r  <= in_item;
      func_r  <= func_t'(in_func);
    end
    if (cmd.apply) begin
      res_found    <= hit;
      res_position <= hit ? 8'(hit_idx) + 8'd1 : 8'd0;
      res_count    <= 8'(count_nxt);
      res_status   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/dedup_set_table_top.sv =====
// Top level of the de-duplicating set table: controller and datapath joined.
//
//   channel | direction | tdata                      | tuser
//   in_     | in        | item[31:0]                 | func[1:0]
//   out_    | out       | found, position, count     | status[1:0]
//
// Each operation has a compare step and an update step: the beat is accepted and
// compared against all live cells at once, then the update step applies add, remove
// or clear and loads the result register. One operation is in flight at a time.
// A result waiting on out_tready does not block the next input beat; only the
// update step waits for the result register to drain.
// Synchronous active-low reset empties the set; the cell contents need no clearing.
module dedup_set_table_top
  import dst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] item
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] found, [8:1] position, [16:9] count, [23:17] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  dst_cmd_t   cmd;
  logic       res_found;
  logic [7:0] res_position;
  logic [7:0] res_count;

  dst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dst_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_tuser),
    .in_item      (in_tdata[ITEM_BITS-1:0]),
    .res_found    (res_found),
    .res_position (res_position),
    .res_count    (res_count),
    .res_status   (out_tuser)
  );

  assign out_tdata = {7'd0, res_count, res_position, res_found};

endmodule

// ===== design/dst_checker.sv =====
// Port-level checker for the set table, bound to the top level.
module dst_checker
  import dst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Only one operation is in flight: an accepted beat closes the input in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during an operation");

  // Found and a non-zero position always agree.
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[8:1] != 8'd0)))
    else $error("found and position disagree");

  // A full store reports the capacity as its count and no match.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (out_tdata[16:9] == 8'(CAPACITY)) && !out_tdata[0])
    else $error("full status with wrong count or a match");

  // A duplicate report points at an existing entry within the count.
  a_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DUP) |->
      out_tdata[0] && (out_tdata[8:1] <= out_tdata[16:9]))
    else $error("duplicate status without a valid position");

endmodule

bind dedup_set_table_top dst_checker u_dst_checker (.*);

// ===== dv/dedup_set_table_top_test.sv =====
// Self-checking testbench for the de-duplicating set table, with a set mirror as scoreboard.
module dedup_set_table_top_test
  import dst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 850;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bit       found;
    bit [7:0] position;
    bit [7:0] count;
    status_t  status;
  } set_reply_t;

  // Mirrors the set contents and keeps the replies that the block still owes.
  class set_mirror;
    bit [ITEM_BITS-1:0] members[$];
    set_reply_t         replies_due[$];
    int unsigned        errors;

    function int lookup(bit [ITEM_BITS-1:0] v);
      foreach (members[i]) begin
        if (members[i] == v) return i + 1;
      end
      return 0;
    endfunction

    function void note_op(func_t f, bit [ITEM_BITS-1:0] v);
      set_reply_t r;
      int         pos;
      pos        = lookup(v);
      r.found    = (pos != 0);
      r.position = pos[7:0];
      r.status   = ST_DONE;
      case (f)
        OP_ADD: begin
          if (pos != 0) r.status = ST_DUP;
          else if (members.size() >= CAPACITY) r.status = ST_FULL;
          else members.push_back(v);
        end
        OP_REMOVE: begin
          if (pos == 0) r.status = ST_ABSENT;
          else members.delete(pos - 1);
        end
        OP_CLEAR: begin
          members.delete();
        end
        default: begin
        end
      endcase
      r.count = 8'(members.size());
      replies_due.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_reply(logic [23:0] data, logic [1:0] user);
      set_reply_t r;
      if (replies_due.size() == 0) begin
        report("result beat arrived with nothing outstanding");
        return;
      end
      r = replies_due.pop_front();
      if (data[0] !== r.found)
        report($sformatf("found %b, expected %b", data[0], r.found));
      if (data[8:1] !== r.position)
        report($sformatf("position %0d, expected %0d", data[8:1], r.position));
      if (data[16:9] !== r.count)
        report($sformatf("count %0d, expected %0d", data[16:9], r.count));
      if (data[23:17] !== 7'd0)
        report($sformatf("padding bits %h are not zero", data[23:17]));
      if (user !== r.status)
        report($sformatf("status %0d, expected %0d", user, r.status));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  func_t       in_tuser   = OP_QUERY;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  set_mirror sb = new();
  int        sent      = 0;
  int        cycles    = 0;
  bit        stalls_on = 1'b1;
  bit        hold_req  = 1'b0;

  dedup_set_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tdata, out_tuser);
  end

  // Receiver: short random stalls, plus one long hold-off that lets the block back up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one beat and returns once it has been taken; called at a rising edge.
  task automatic send(func_t f, bit [31:0] v);
    if (sent == 300) hold_req = 1'b1;
    stalls_on = (sent < ITEMS - 70);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(f, v);
    sent++;
  endtask

  // Mostly live members, some values one bit away from a member, the rest random.
  function automatic bit [31:0] pick_item();
    int k;
    k = $urandom_range(0, 9);
    if (sb.members.size() == 0 || k < 3) return $urandom();
    if (k < 8) return sb.members[$urandom_range(0, sb.members.size() - 1)];
    return sb.members[$urandom_range(0, sb.members.size() - 1)] ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic fill_up();
    int k;
    while (sb.members.size() < CAPACITY) begin
      k = $urandom_range(0, 9);
      if (k == 0) send(OP_QUERY, pick_item());
      else if (k == 1) send(OP_ADD, pick_item());
      else send(OP_ADD, $urandom());
    end
    send(OP_ADD, $urandom());
    send(OP_ADD, sb.members[$urandom_range(0, CAPACITY - 1)]);
    send(OP_QUERY, sb.members[CAPACITY - 1]);
    send(OP_REMOVE, sb.members[$urandom_range(1, CAPACITY - 2)]);
    send(OP_ADD, $urandom());
    send(OP_ADD, $urandom());
  endtask

  task automatic churn(int n, bit draining);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 19);
      if (draining) begin
        if (k < 14) send(OP_REMOVE, pick_item());
        else send(OP_QUERY, pick_item());
      end else if (k == 0) send(OP_CLEAR, pick_item());
      else if (k < 8) send(OP_ADD, pick_item());
      else if (k < 14) send(OP_REMOVE, pick_item());
      else send(OP_QUERY, pick_item());
    end
  endtask

  initial begin
    int episode;
    episode = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty set, field extremes, single-bit neighbours, duplicates and shifting removes.
    send(OP_QUERY,  32'h0000_0000);
    send(OP_REMOVE, 32'h0000_0000);
    send(OP_ADD,    32'h0000_0000);
    send(OP_ADD,    32'hFFFF_FFFF);
    send(OP_ADD,    32'h0000_0000);
    send(OP_ADD,    32'h0000_0001);
    send(OP_ADD,    32'h8000_0000);
    send(OP_QUERY,  32'hFFFF_FFFF);
    send(OP_QUERY,  32'h7FFF_FFFF);
    send(OP_REMOVE, 32'h0000_0000);
    send(OP_QUERY,  32'h0000_0001);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_REMOVE, 32'h8000_0000);
    send(OP_ADD,    32'h8000_0000);
    send(OP_CLEAR,  32'hFFFF_FFFF);
    send(OP_QUERY,  32'hFFFF_FFFF);
    send(OP_CLEAR,  32'h0000_0000);
    send(OP_ADD,    32'hA5A5_A5A5);
    send(OP_QUERY,  32'hA5A5_A5A5);
    send(OP_REMOVE, 32'hA5A5_A5A5);
    send(OP_QUERY,  32'hA5A5_A5A5);

    while (sent < ITEMS) begin
      case (episode % 4)
        0: fill_up();
        1: churn(60, 1'b1);
        2: churn(80, 1'b0);
        default: begin
          send(OP_CLEAR, pick_item());
          churn(40, 1'b0);
        end
      endcase
      episode++;
    end
    in_tvalid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
